// File: rtl/sfc_pkg.sv
// ============================================================================
// sfc_pkg
// Shared types and codes for the sensor frame checker.
// ============================================================================
package sfc_pkg;

   // beat kinds on the request side (req_tuser)
   localparam logic [1:0] ACT_BYTE = 2'd0;   // received serial byte
   localparam logic [1:0] ACT_IDLE = 2'd1;   // idle line, frame ends
   localparam logic [1:0] ACT_READ = 2'd2;   // table read

   // result status codes (rsp_tuser)
   localparam logic [2:0] STAT_OK    = 3'd0;
   localparam logic [2:0] STAT_LEN   = 3'd1;
   localparam logic [2:0] STAT_HDR   = 3'd2;
   localparam logic [2:0] STAT_CSUM  = 3'd3;
   localparam logic [2:0] STAT_INDEX = 3'd4;

   // header register reset value
   localparam logic [7:0] HEADER_RESET = 8'h62;

   // byte positions inside a frame
   localparam logic [4:0] POS_HEADER = 5'd0;
   localparam logic [4:0] POS_INDEX  = 5'd4;
   localparam logic [4:0] POS_DHIGH  = 5'd5;
   localparam logic [4:0] POS_DLOW   = 5'd6;
   localparam logic [4:0] POS_CHECK  = 5'd8;

   // bytes 0..XOR_SPAN-1 enter the checksum
   localparam logic [4:0] XOR_SPAN  = 5'd8;
   localparam logic [4:0] COUNT_MAX = 5'd31;

   // the table can only be read through a 4-bit slot
   localparam int READ_SLOTS = 16;

   // frame capture state as seen by the checker
   typedef struct packed {
      logic [4:0]  count;
      logic [7:0]  first;
      logic [7:0]  index;
      logic [15:0] distance;
      logic [7:0]  sum;
      logic [7:0]  check;
   } frame_sum_type;

endpackage

// File: rtl/sensor_frame_checker_core.sv
// ============================================================================
// sensor_frame_checker_core
// Serial sensor frame checker: header, length and XOR checks, distance table.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser action, tdata read_slot|data_byte
//  rsp      out  rsp_tvalid/rsp_tready  tuser status, tdata distance|sensor_slot
//  csr      in   csr_valid/csr_ready    csr_data header_byte
//
// One beat per cycle while not stalled: input register, one level of check logic,
// result register. A beat's result is registered behind the input register.
// Byte and unused beats produce no result and never wait on rsp_tready.
// Idle and read beats hold in the input stage while a pending result is not taken.
// Synchronous reset clears the frame state, table and header (to 0x62).
// ============================================================================
module sensor_frame_checker_core #(
   parameter int FRAME_BYTES  = 10,
   parameter int SENSOR_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request: tuser = action[1:0]; tdata = data_byte[7:0], read_slot[11:8], pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [15:0] req_tdata,
   // response: tuser = status[2:0]; tdata = sensor_slot[3:0], distance[19:4], pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,
   output logic [23:0] rsp_tdata,
   // header register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int TABLE_DEPTH = (SENSOR_SLOTS < sfc_pkg::READ_SLOTS) ?
                                SENSOR_SLOTS : sfc_pkg::READ_SLOTS;
   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [4:0] FRAME_CNT = 5'(FRAME_BYTES);
   localparam logic [8:0] SLOT_LIM  = 9'(SENSOR_SLOTS);
   localparam logic [8:0] DEPTH_LIM = 9'(TABLE_DEPTH);

   // header register
   logic [7:0] header_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= sfc_pkg::HEADER_RESET;
      end else if (csr_valid) begin
         header_ff <= csr_data;
      end
   end

   // input stage
   logic       s1_valid_ff;
   logic [1:0] s1_action_ff;
   logic [7:0] s1_byte_ff;
   logic [3:0] s1_slot_ff;
   logic       has_result;
   logic       rsp_free;
   logic       s1_adv;
   logic       req_take;

   assign has_result = (s1_action_ff == sfc_pkg::ACT_IDLE) ||
                       (s1_action_ff == sfc_pkg::ACT_READ);
   assign rsp_free   = !rsp_tvalid || rsp_tready;
   assign s1_adv     = s1_valid_ff && (!has_result || rsp_free);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_tuser;
         s1_byte_ff   <= req_tdata[7:0];
         s1_slot_ff   <= req_tdata[11:8];
      end
   end

   // frame capture
   sfc_pkg::frame_sum_type frame_sum;

   sfc_frame_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .step_en   (s1_adv),
      .action    (s1_action_ff),
      .data_byte (s1_byte_ff),
      .frame_sum (frame_sum)
   );

   // frame checks, in priority order
   logic [2:0]  idle_status;
   logic [7:0]  wr_idx;
   logic        idx_bad;

   assign wr_idx  = frame_sum.index - 8'd1;
   assign idx_bad = (frame_sum.index == 8'd0) || ({1'b0, frame_sum.index} > SLOT_LIM);

   always_comb begin
      if (frame_sum.count != FRAME_CNT) begin
         idle_status = sfc_pkg::STAT_LEN;
      end else if (frame_sum.first != header_ff) begin
         idle_status = sfc_pkg::STAT_HDR;
      end else if (frame_sum.check != frame_sum.sum) begin
         idle_status = sfc_pkg::STAT_CSUM;
      end else if (idx_bad) begin
         idle_status = sfc_pkg::STAT_INDEX;
      end else begin
         idle_status = sfc_pkg::STAT_OK;
      end
   end

   // distance table; slots past what a read can reach are never stored
   logic        tbl_wr_en;
   logic [15:0] tbl_rd_data;

   assign tbl_wr_en = s1_adv && (s1_action_ff == sfc_pkg::ACT_IDLE) &&
                      (idle_status == sfc_pkg::STAT_OK) && ({1'b0, wr_idx} < DEPTH_LIM);

   sfc_dist_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (wr_idx[SLOT_W-1:0]),
      .wr_data (frame_sum.distance),
      .rd_addr (s1_slot_ff[SLOT_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   // result select
   logic [2:0]  res_status;
   logic [3:0]  res_slot;
   logic [15:0] res_dist;

   always_comb begin
      res_status = sfc_pkg::STAT_OK;
      res_slot   = '0;
      res_dist   = '0;
      case (s1_action_ff)
         sfc_pkg::ACT_IDLE: begin
            res_status = idle_status;
            if (idle_status == sfc_pkg::STAT_OK) begin
               res_slot = wr_idx[3:0];
               res_dist = frame_sum.distance;
            end
         end
         sfc_pkg::ACT_READ: begin
            res_slot = s1_slot_ff;
            if ({5'd0, s1_slot_ff} >= SLOT_LIM) begin
               res_status = sfc_pkg::STAT_INDEX;
            end else begin
               res_dist = tbl_rd_data;
            end
         end
         default: ;
      endcase
   end

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [3:0]  rsp_slot_ff;
   logic [15:0] rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && has_result) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_dist_ff   <= res_dist;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'd0, rsp_dist_ff, rsp_slot_ff};

`ifndef NO_ASSERTIONS
   // a table write only ever comes from a frame that passed every check
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> (s1_action_ff == sfc_pkg::ACT_IDLE) && (idle_status == sfc_pkg::STAT_OK))
      else $error("table write from a rejected frame");

   // an idle beat restarts the frame count and checksum
   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (s1_action_ff == sfc_pkg::ACT_IDLE) |=>
         (frame_sum.count == 5'd0) && (frame_sum.sum == 8'd0))
      else $error("frame state not cleared after idle");

   // a result-producing beat never leaves while a result is stuck
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && s1_valid_ff && has_result |=> s1_valid_ff)
      else $error("pending result overwritten");

   // byte beats never create a result
   a_byte_silent: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (s1_action_ff == sfc_pkg::ACT_BYTE) && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result raised by a byte beat");
`endif

endmodule

// File: rtl/sfc_frame_acc.sv
// ============================================================================
// sfc_frame_acc
// Byte counter, field capture and running XOR for the frame being received.
// ============================================================================
module sfc_frame_acc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,    // request beat leaves the input stage
   input  logic [1:0]            action,
   input  logic [7:0]            data_byte,
   output sfc_pkg::frame_sum_type frame_sum
);

   logic [4:0] count_ff, count_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] index_ff, index_in;
   logic [7:0] dhigh_ff, dhigh_in;
   logic [7:0] dlow_ff,  dlow_in;
   logic [7:0] sum_ff,   sum_in;
   logic [7:0] check_ff, check_in;

   // next state
   always_comb begin
      count_in = count_ff;
      first_in = first_ff;
      index_in = index_ff;
      dhigh_in = dhigh_ff;
      dlow_in  = dlow_ff;
      sum_in   = sum_ff;
      check_in = check_ff;
      if (step_en) begin
         case (action)
            sfc_pkg::ACT_BYTE: begin
               case (count_ff)
                  sfc_pkg::POS_HEADER: first_in = data_byte;
                  sfc_pkg::POS_INDEX:  index_in = data_byte;
                  sfc_pkg::POS_DHIGH:  dhigh_in = data_byte;
                  sfc_pkg::POS_DLOW:   dlow_in  = data_byte;
                  sfc_pkg::POS_CHECK:  check_in = data_byte;
                  default: ;
               endcase
               if (count_ff < sfc_pkg::XOR_SPAN) begin
                  sum_in = sum_ff ^ data_byte;
               end
               // saturating count
               if (count_ff != sfc_pkg::COUNT_MAX) begin
                  count_in = count_ff + 5'd1;
               end
            end
            sfc_pkg::ACT_IDLE: begin
               count_in = '0;
               sum_in   = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         index_ff <= '0;
         dhigh_ff <= '0;
         dlow_ff  <= '0;
         sum_ff   <= '0;
         check_ff <= '0;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
         index_ff <= index_in;
         dhigh_ff <= dhigh_in;
         dlow_ff  <= dlow_in;
         sum_ff   <= sum_in;
         check_ff <= check_in;
      end
   end

   assign frame_sum.count    = count_ff;
   assign frame_sum.first    = first_ff;
   assign frame_sum.index    = index_ff;
   assign frame_sum.distance = {dhigh_ff, dlow_ff};
   assign frame_sum.sum      = sum_ff;
   assign frame_sum.check    = check_ff;

endmodule

// File: rtl/sfc_dist_table.sv
// ============================================================================
// sfc_dist_table
// Per-sensor distance table, one write and one read port, cleared on reset.
// ============================================================================
module sfc_dist_table #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [15:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [15:0]                         rd_data
);

   logic [15:0] entry_ff [DEPTH];

   // write port; reset brings every entry back to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   // read port, caller guards the range
   assign rd_data = entry_ff[rd_addr];

endmodule

// File: test/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for sensor_frame_checker_core.
//
// A directed table first walks reset reads, empty, short, long and saturating
// frames, each reject code and the order of the checks. Random frames follow,
// mostly well-formed with some corruption, plus broken frames, lone idles,
// table reads and unused beats. The header register is changed between
// phases. A beat-level predictor tracks frame capture and the distance
// table. Every response beat is compared against the oldest expected report.
// ============================================================================
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BYTES  = 10;
   localparam int SENSOR_SLOTS = 16;
   localparam int SETTLE_CYCLES = 8;        // well past the pipeline tail
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_BEATS  = 360;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [15:0] distance;
   } frame_report_type;

   typedef enum {ROW_FRAME, ROW_READ, ROW_NOISE} plan_kind_type;

   typedef struct {
      plan_kind_type    kind;
      int               len;
      logic [7:0]       hdr;
      logic [7:0]       idx;
      logic [15:0]      distance;
      logic [7:0]       flip;
      logic [3:0]       slot;
      bit               typed;
      frame_report_type want;
   } plan_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = ACT_UNUSED;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [23:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   // predictor state
   logic [7:0]  hdr_reg = sfc_pkg::HEADER_RESET;
   logic [4:0]  rx_count = '0;
   logic [7:0]  rx_first = '0;
   logic [7:0]  rx_index = '0;
   logic [7:0]  rx_dhigh = '0;
   logic [7:0]  rx_dlow  = '0;
   logic [7:0]  rx_xor   = '0;
   logic [7:0]  rx_check = '0;
   logic [15:0] dist_mem [0:SENSOR_SLOTS-1];

   frame_report_type reports_due [$];
   plan_row_type     plan [$];
   int               errors = 0;
   int               counted = 0;
   int               cycle_count = 0;
   bit               steady = 1'b0;    // no idling on either side while set

   sensor_frame_checker_core #(
      .FRAME_BYTES  (FRAME_BYTES),
      .SENSOR_SLOTS (SENSOR_SLOTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      $display("mismatch at cycle %0d: %s, expected %0h, got %0h",
               cycle_count, what, want, got);
      errors++;
   endtask

   // frame capture and table update for one accepted request beat
   task automatic predict_frame_report(input logic [1:0] act, input logic [7:0] data,
                                       input logic [3:0] slot, output bit has,
                                       output frame_report_type rep);
      logic [4:0] cnt;
      logic [7:0] sum;
      has = 1'b0;
      rep = '0;
      case (act)
         sfc_pkg::ACT_BYTE: begin
            if (rx_count == sfc_pkg::POS_HEADER) rx_first = data;
            else if (rx_count == sfc_pkg::POS_INDEX) rx_index = data;
            else if (rx_count == sfc_pkg::POS_DHIGH) rx_dhigh = data;
            else if (rx_count == sfc_pkg::POS_DLOW) rx_dlow = data;
            else if (rx_count == sfc_pkg::POS_CHECK) rx_check = data;
            if (rx_count < sfc_pkg::XOR_SPAN) rx_xor = rx_xor ^ data;
            if (rx_count < sfc_pkg::COUNT_MAX) rx_count = rx_count + 5'd1;
         end
         sfc_pkg::ACT_IDLE: begin
            has = 1'b1;
            cnt = rx_count;
            sum = rx_xor;
            rx_count = '0;
            rx_xor = '0;
            // checks in order: length, header, checksum, index
            if (int'(cnt) != FRAME_BYTES) rep.status = sfc_pkg::STAT_LEN;
            else if (rx_first != hdr_reg) rep.status = sfc_pkg::STAT_HDR;
            else if (rx_check != sum) rep.status = sfc_pkg::STAT_CSUM;
            else if (rx_index == 8'd0 || int'(rx_index) > SENSOR_SLOTS)
               rep.status = sfc_pkg::STAT_INDEX;
            else begin
               rep.status = sfc_pkg::STAT_OK;
               rep.slot = 4'(rx_index - 8'd1);
               rep.distance = {rx_dhigh, rx_dlow};
               dist_mem[int'(rx_index) - 1] = rep.distance;
            end
         end
         sfc_pkg::ACT_READ: begin
            has = 1'b1;
            rep.slot = slot;
            if (int'(slot) >= SENSOR_SLOTS) rep.status = sfc_pkg::STAT_INDEX;
            else begin
               rep.status = sfc_pkg::STAT_OK;
               rep.distance = dist_mem[slot];
            end
         end
         default: ;
      endcase
   endtask

   // one request beat, with random gaps ahead of it
   task automatic send_beat(input logic [1:0] act, input logic [7:0] data,
                            input logic [3:0] slot, input bit typed,
                            input frame_report_type want);
      bit               has;
      frame_report_type rep;
      while (!steady && $urandom_range(0, 99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'h0, slot, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frame_report(act, data, slot, has, rep);
      if (has) reports_due.push_back(typed ? want : rep);
      if (act != ACT_UNUSED) counted++;
   endtask

   // a frame of len bytes, then the idle beat; flip corrupts the check byte
   task automatic send_frame(input int len, input logic [7:0] hdr, input logic [7:0] idx,
                             input logic [15:0] distance, input logic [7:0] flip,
                             input bit mix, input bit typed, input frame_report_type want);
      logic [7:0] fb [0:47];
      logic [7:0] sum;
      int         k;
      int         r;
      for (k = 0; k < 48; k++) fb[k] = 8'($urandom_range(0, 255));
      fb[0] = hdr;
      fb[4] = idx;
      fb[5] = distance[15:8];
      fb[6] = distance[7:0];
      sum = '0;
      for (k = 0; k < 8; k++) sum = sum ^ fb[k];
      fb[8] = sum ^ flip;
      for (k = 0; k < len; k++) begin
         // unused beats and reads dropped into the middle of a frame
         if (mix) begin
            r = $urandom_range(0, 99);
            if (r < 2)
               send_beat(ACT_UNUSED, 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, 15)), 1'b0, '0);
            else if (r < 4)
               send_beat(sfc_pkg::ACT_READ, 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, 15)), 1'b0, '0);
         end
         send_beat(sfc_pkg::ACT_BYTE, fb[k], 4'($urandom_range(0, 15)), 1'b0, '0);
      end
      send_beat(sfc_pkg::ACT_IDLE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                typed, want);
   endtask

   // drop valid, wait out every expected report and the pipeline tail
   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_header(input logic [7:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      hdr_reg = value;
   endtask

   task automatic add_row(input plan_kind_type kind, input int len, input logic [7:0] hdr,
                          input logic [7:0] idx, input logic [15:0] distance,
                          input logic [7:0] flip, input logic [3:0] slot, input bit typed,
                          input logic [2:0] st, input logic [3:0] wslot,
                          input logic [15:0] wdist);
      plan_row_type row;
      row.kind = kind;
      row.len = len;
      row.hdr = hdr;
      row.idx = idx;
      row.distance = distance;
      row.flip = flip;
      row.slot = slot;
      row.typed = typed;
      row.want.status = st;
      row.want.slot = wslot;
      row.want.distance = wdist;
      plan.push_back(row);
   endtask

   task automatic run_random_phase(input int goal);
      int            start;
      int            pick;
      int            len;
      logic [7:0]    hdr;
      logic [7:0]    idx;
      logic [15:0]   distance;
      logic [7:0]    flip;
      start = counted;
      while (counted - start < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            // well-formed frame, sometimes with one or more fields spoiled
            hdr = ($urandom_range(0, 99) < 92) ? hdr_reg
                  : hdr_reg ^ 8'($urandom_range(1, 255));
            case ($urandom_range(0, 19))
               0:       idx = 8'd0;
               1:       idx = 8'(SENSOR_SLOTS + 1);
               2:       idx = 8'($urandom_range(SENSOR_SLOTS + 1, 255));
               default: idx = 8'($urandom_range(1, SENSOR_SLOTS));
            endcase
            case ($urandom_range(0, 9))
               0:       distance = 16'h0000;
               1:       distance = 16'hFFFF;
               default: distance = 16'($urandom_range(0, 65535));
            endcase
            flip = ($urandom_range(0, 99) < 88) ? 8'h00 : 8'($urandom_range(1, 255));
            send_frame(FRAME_BYTES, hdr, idx, distance, flip, 1'b1, 1'b0, '0);
         end else if (pick < 74) begin
            send_beat(sfc_pkg::ACT_READ, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 1'b0, '0);
         end else if (pick < 88) begin
            // broken frame: random length, header and check byte each right half the time
            len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 14)
                  : $urandom_range(15, 42);
            hdr = $urandom_range(0, 1) ? hdr_reg : 8'($urandom_range(0, 255));
            flip = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
            send_frame(len, hdr, 8'($urandom_range(0, 20)), 16'($urandom_range(0, 65535)),
                       flip, 1'b1, 1'b0, '0);
         end else if (pick < 94) begin
            send_beat(sfc_pkg::ACT_IDLE, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 3))
               send_beat(ACT_UNUSED, 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, 15)), 1'b0, '0);
         end
      end
   endtask

   // response side: random back-pressure and in-order checking
   always @(posedge clock) begin
      frame_report_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reports_due.size() == 0)
            note_mismatch("response beat with nothing due", '0,
                          32'({rsp_tuser, rsp_tdata}));
         else begin
            due = reports_due.pop_front();
            if (rsp_tuser != due.status)
               note_mismatch("status", 32'(due.status), 32'(rsp_tuser));
            if (rsp_tdata[3:0] != due.slot)
               note_mismatch("sensor_slot", 32'(due.slot), 32'(rsp_tdata[3:0]));
            if (rsp_tdata[19:4] != due.distance)
               note_mismatch("distance", 32'(due.distance), 32'(rsp_tdata[19:4]));
         end
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= 23);
   end

   initial begin
      plan_row_type row;
      int           k;
      for (k = 0; k < SENSOR_SLOTS; k++) dist_mem[k] = '0;

      // directed plan, header at its reset value
      add_row(ROW_READ,  0, 8'h00, 8'd0, 16'h0000, 8'h00, 4'd0, 1'b1,
              sfc_pkg::STAT_OK, 4'd0, 16'h0000);
      add_row(ROW_READ,  0, 8'h00, 8'd0, 16'h0000, 8'h00, 4'd15, 1'b1,
              sfc_pkg::STAT_OK, 4'd15, 16'h0000);
      // empty frame
      add_row(ROW_FRAME, 0, sfc_pkg::HEADER_RESET, 8'd1, 16'h0000, 8'h00, 4'd0, 1'b1,
              sfc_pkg::STAT_LEN, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'd1, 16'hFFFF, 8'h00, 4'd0,
              1'b1, sfc_pkg::STAT_OK, 4'd0, 16'hFFFF);
      add_row(ROW_FRAME, FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'(SENSOR_SLOTS), 16'h0000,
              8'h00, 4'd0, 1'b1, sfc_pkg::STAT_OK, 4'(SENSOR_SLOTS - 1), 16'h0000);
      // index bytes outside the table
      add_row(ROW_FRAME, FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'd0, 16'h1111, 8'h00, 4'd0,
              1'b1, sfc_pkg::STAT_INDEX, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'(SENSOR_SLOTS + 1), 16'h2222,
              8'h00, 4'd0, 1'b1, sfc_pkg::STAT_INDEX, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'hFF, 16'h3333, 8'h00, 4'd0,
              1'b1, sfc_pkg::STAT_INDEX, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES, 8'h61, 8'd2, 16'h4444, 8'h00, 4'd0, 1'b1,
              sfc_pkg::STAT_HDR, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'd3, 16'h5555, 8'h80, 4'd0,
              1'b1, sfc_pkg::STAT_CSUM, 4'd0, '0);
      // check order: header before checksum, checksum before index
      add_row(ROW_FRAME, FRAME_BYTES, 8'h00, 8'd3, 16'h6666, 8'h01, 4'd0, 1'b1,
              sfc_pkg::STAT_HDR, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'd0, 16'h7777, 8'hFF, 4'd0,
              1'b1, sfc_pkg::STAT_CSUM, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES - 1, sfc_pkg::HEADER_RESET, 8'd4, 16'h8888, 8'h00,
              4'd0, 1'b1, sfc_pkg::STAT_LEN, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES + 1, sfc_pkg::HEADER_RESET, 8'd4, 16'h9999, 8'h00,
              4'd0, 1'b1, sfc_pkg::STAT_LEN, 4'd0, '0);
      // count saturates: a wrapping counter would land on the frame size here
      add_row(ROW_FRAME, 32 + FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'd5, 16'hAAAA, 8'h00,
              4'd0, 1'b1, sfc_pkg::STAT_LEN, 4'd0, '0);
      add_row(ROW_FRAME, 1, 8'h00, 8'd5, 16'hBBBB, 8'h00, 4'd0, 1'b1,
              sfc_pkg::STAT_LEN, 4'd0, '0);
      add_row(ROW_NOISE, 0, 8'h00, 8'd0, 16'h0000, 8'h00, 4'd9, 1'b0,
              sfc_pkg::STAT_OK, 4'd0, '0);
      add_row(ROW_READ,  0, 8'h00, 8'd0, 16'h0000, 8'h00, 4'd0, 1'b0,
              sfc_pkg::STAT_OK, 4'd0, '0);
      add_row(ROW_READ,  0, 8'h00, 8'd0, 16'h0000, 8'h00, 4'd15, 1'b0,
              sfc_pkg::STAT_OK, 4'd0, '0);
      add_row(ROW_FRAME, FRAME_BYTES, sfc_pkg::HEADER_RESET, 8'd8, 16'h1234, 8'h00, 4'd0,
              1'b0, sfc_pkg::STAT_OK, 4'd0, '0);
      add_row(ROW_READ,  0, 8'h00, 8'd0, 16'h0000, 8'h00, 4'd7, 1'b0,
              sfc_pkg::STAT_OK, 4'd0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         row = plan[k];
         case (row.kind)
            ROW_FRAME: send_frame(row.len, row.hdr, row.idx, row.distance, row.flip, 1'b0,
                                  row.typed, row.want);
            ROW_READ:  send_beat(sfc_pkg::ACT_READ, 8'($urandom_range(0, 255)), row.slot,
                                 row.typed, row.want);
            default:   send_beat(ACT_UNUSED, 8'hFF, row.slot, 1'b0, '0);
         endcase
      end

      // random phases under different header settings
      write_header(8'h00);
      run_random_phase(PHASE_BEATS);
      write_header(8'hFF);
      steady <= 1'b1;
      run_random_phase(PHASE_BEATS);
      steady <= 1'b0;
      write_header(8'($urandom_range(1, 254)));
      run_random_phase(PHASE_BEATS);
      write_header(sfc_pkg::HEADER_RESET);
      run_random_phase(PHASE_BEATS);

      settle_block();
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sensor_frame_checker_core.f
rtl/sfc_pkg.sv
rtl/sfc_frame_acc.sv
rtl/sfc_dist_table.sv
rtl/sensor_frame_checker_core.sv
test/tb_top.sv
